// ===== hw/rtl/bsr_pkg.sv =====
// Shared constants and command codes for the blackout span recorder.
`timescale 1ns / 1ps
package bsr_pkg;
  localparam int TS_W          = 64;
  localparam int IDX_W         = 7;
  localparam int CNT_OUT_W     = 7;
  localparam int CMD_W         = 2;
  localparam int MAX_SPANS_DEF = 64;

  localparam logic [CMD_W-1:0] CMD_OFF    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ON     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COVERS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  localparam logic [TS_W-1:0] TS_ALL_ONES = {TS_W{1'b1}};
endpackage

// ===== hw/rtl/bsr_span_store.sv =====
// Span table memory: start/end pairs, registered read, range probe.
`timescale 1ns / 1ps
module bsr_span_store #(
  parameter int MAX_SPANS = bsr_pkg::MAX_SPANS_DEF,
  parameter int AW        = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [bsr_pkg::TS_W-1:0] wr_start,
  input  logic [bsr_pkg::TS_W-1:0] wr_end,
  input  logic [AW-1:0]           rd_addr,
  input  logic [bsr_pkg::TS_W-1:0] probe_ts,
  output logic [bsr_pkg::TS_W-1:0] rd_start,
  output logic [bsr_pkg::TS_W-1:0] rd_end,
  output logic                    hit
);
  import bsr_pkg::*;

  logic [2*TS_W-1:0] mem [MAX_SPANS];
  logic [2*TS_W-1:0] rd_word_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_start, wr_end};
    end
    rd_word_r <= mem[rd_addr];
  end

  assign rd_start = rd_word_r[2*TS_W-1:TS_W];
  assign rd_end   = rd_word_r[TS_W-1:0];
  assign hit      = (probe_ts >= rd_start) && (probe_ts <= rd_end);
endmodule

// ===== hw/rtl/blackout_span_recorder_core.sv =====
// Blackout span recorder top level: command decode, sequencer, result register.
//
// Usage: one command word enters on in_* (valid/stall); exactly one result
// word leaves on out_* for each. Off/on events update the open period and
// the span table; a covers query scans the table; a span read fetches one
// entry. The block handles one word at a time.
// Steps from acceptance to the result:
//   off/on event, out-of-range read, covers on empty table: straight to done
//   span read of a stored entry: one memory read, then done
//   covers query: scans the stored entries in order until a hit or the
//   end of the table, so at most MAX_SPANS entries; the single memory read
//   port delivers one entry per cycle.
// A result waits in the output register while out_stall is high; the next
// word is taken meanwhile, and its result waits in a holding register.
// Reset clears the span count and the open period; table contents are left
// as they are and only entries below the count ever reach a result.
`timescale 1ns / 1ps
module blackout_span_recorder_core #(
  parameter int MAX_SPANS = bsr_pkg::MAX_SPANS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bsr_pkg::CMD_W-1:0]     in_cmd,
  input  logic [bsr_pkg::TS_W-1:0]      in_timestamp,
  input  logic [bsr_pkg::IDX_W-1:0]     in_span_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_found,
  output logic [bsr_pkg::TS_W-1:0]      out_span_start,
  output logic [bsr_pkg::TS_W-1:0]      out_span_end,
  output logic [bsr_pkg::CNT_OUT_W-1:0] out_span_count,
  output logic                         out_table_full
);
  import bsr_pkg::*;

  localparam int AW   = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
  localparam int CNTW = $clog2(MAX_SPANS + 1);
  localparam int CW   = (CNTW + 1 > IDX_W) ? CNTW + 1 : IDX_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_RWAIT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_r;
  logic [CNTW-1:0]  count_r;
  logic             open_r;
  logic [TS_W-1:0]  open_start_r;
  logic [TS_W-1:0]  ts_r;
  logic [AW-1:0]    ptr_r;

  logic             res_found_r;
  logic [TS_W-1:0]  res_start_r;
  logic [TS_W-1:0]  res_end_r;
  logic             res_full_r;

  logic                 out_valid_r;
  logic                 out_found_r;
  logic [TS_W-1:0]      out_start_r;
  logic [TS_W-1:0]      out_end_r;
  logic [CNT_OUT_W-1:0] out_count_r;
  logic                 out_full_r;

  logic            accept;
  logic [CW-1:0]   idx_ext;
  logic [CW-1:0]   count_ext;
  logic [CW-1:0]   total_ext;
  logic            idx_in_range;
  logic            table_full;
  logic            scan_last;
  logic            out_free;
  logic            wr_en;
  logic [AW-1:0]   rd_addr;
  logic [TS_W-1:0] rd_start;
  logic [TS_W-1:0] rd_end;
  logic            hit;

  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign idx_ext      = CW'(in_span_index);
  assign count_ext    = CW'(count_r);
  assign total_ext    = count_ext + CW'(open_r);
  assign idx_in_range = idx_ext < count_ext;
  assign table_full   = (count_r == CNTW'(MAX_SPANS));
  assign scan_last    = (CW'(ptr_r) + CW'(1)) == count_ext;
  assign out_free     = !out_valid_r || !out_stall;
  assign wr_en        = accept && (in_cmd == CMD_ON) && open_r && !table_full;

  always_comb begin
    unique case (state_r)
      S_IDLE:  rd_addr = (in_cmd == CMD_READ) ? idx_ext[AW-1:0] : '0;
      S_SCAN:  rd_addr = ptr_r + AW'(1);
      default: rd_addr = '0;
    endcase
  end

  bsr_span_store #(
    .MAX_SPANS(MAX_SPANS),
    .AW       (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_start(open_start_r),
    .wr_end  (in_timestamp),
    .rd_addr (rd_addr),
    .probe_ts(ts_r),
    .rd_start(rd_start),
    .rd_end  (rd_end),
    .hit     (hit)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      open_r       <= 1'b0;
      open_start_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_cmd)
              CMD_OFF: begin
                if (!open_r) begin
                  open_r       <= 1'b1;
                  open_start_r <= in_timestamp;
                end
                state_r <= S_DONE;
              end
              CMD_ON: begin
                if (open_r) begin
                  open_r <= 1'b0;
                  if (!table_full) begin
                    count_r <= count_r + CNTW'(1);
                  end
                end
                state_r <= S_DONE;
              end
              CMD_COVERS: state_r <= (count_r == '0) ? S_DONE : S_SCAN;
              CMD_READ:   state_r <= idx_in_range ? S_RWAIT : S_DONE;
              default:    state_r <= S_DONE;
            endcase
          end
        end
        S_SCAN:  if (hit || scan_last) state_r <= S_DONE;
        S_RWAIT: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ts_r       <= in_timestamp;
          ptr_r      <= '0;
          res_full_r <= (in_cmd == CMD_ON) && open_r && table_full;
          priority if (in_cmd == CMD_COVERS) begin
            res_found_r <= open_r && (in_timestamp >= open_start_r);
            res_start_r <= '0;
            res_end_r   <= '0;
          end else if (in_cmd == CMD_READ && !idx_in_range && open_r &&
                       idx_ext == count_ext) begin
            res_found_r <= 1'b1;
            res_start_r <= open_start_r;
            res_end_r   <= TS_ALL_ONES;
          end else begin
            res_found_r <= 1'b0;
            res_start_r <= '0;
            res_end_r   <= '0;
          end
        end
      end
      S_SCAN: begin
        ptr_r <= ptr_r + AW'(1);
        if (hit) begin
          res_found_r <= 1'b1;
        end
      end
      S_RWAIT: begin
        res_found_r <= 1'b1;
        res_start_r <= rd_start;
        res_end_r   <= rd_end;
      end
      S_DONE: begin
        if (out_free) begin
          out_found_r <= res_found_r;
          out_start_r <= res_start_r;
          out_end_r   <= res_end_r;
          out_count_r <= total_ext[CNT_OUT_W-1:0];
          out_full_r  <= res_full_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_span_start = out_start_r;
  assign out_span_end   = out_end_r;
  assign out_span_count = out_count_r;
  assign out_table_full = out_full_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(count_r) <= CW'(MAX_SPANS))
    else $error("span count above table size");

  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CW'(ptr_r) < count_ext))
    else $error("scan pointer past stored spans");

  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> !out_found_r)
    else $error("dropped span result flagged found");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_free) |=> (state_r == S_DONE))
    else $error("pending result left while output busy");
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the blackout span recorder core.
`timescale 1ns / 1ps
module tb_top;
  import bsr_pkg::*;

  localparam int SPAN_DEPTH = MAX_SPANS_DEF;
  localparam int ITEM_TARGET = 1600;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [TS_W-1:0]  ts;
    logic [IDX_W-1:0] idx;
  } cmd_word_t;

  typedef struct packed {
    logic                 found;
    logic [TS_W-1:0]      span_start;
    logic [TS_W-1:0]      span_end;
    logic [CNT_OUT_W-1:0] span_count;
    logic                 table_full;
  } span_word_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     in_cmd = CMD_OFF;
  logic [TS_W-1:0]      in_timestamp = '0;
  logic [IDX_W-1:0]     in_span_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_found;
  logic [TS_W-1:0]      out_span_start;
  logic [TS_W-1:0]      out_span_end;
  logic [CNT_OUT_W-1:0] out_span_count;
  logic                 out_table_full;

  blackout_span_recorder_core #(.MAX_SPANS(SPAN_DEPTH)) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_timestamp   (in_timestamp),
    .in_span_index  (in_span_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_span_start (out_span_start),
    .out_span_end   (out_span_end),
    .out_span_count (out_span_count),
    .out_table_full (out_table_full)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #8_000_000;
    $display("FAIL blackout_span_recorder_core");
    $finish;
  end

  cmd_word_t  cmd_pending_q[$];
  span_word_t span_expect_q[$];
  int         mismatch_count = 0;

  // span table mirror
  logic [TS_W-1:0] mirror_start[SPAN_DEPTH];
  logic [TS_W-1:0] mirror_end[SPAN_DEPTH];
  int unsigned     mirror_stored = 0;
  logic            mirror_open = 1'b0;
  logic [TS_W-1:0] mirror_open_ts = '0;

  function automatic span_word_t blackout_predict(cmd_word_t w);
    span_word_t r;
    r = '0;
    case (w.cmd)
      CMD_OFF: begin
        if (!mirror_open) begin
          mirror_open = 1'b1;
          mirror_open_ts = w.ts;
        end
      end
      CMD_ON: begin
        if (mirror_open) begin
          if (mirror_stored < SPAN_DEPTH) begin
            mirror_start[mirror_stored] = mirror_open_ts;
            mirror_end[mirror_stored] = w.ts;
            mirror_stored++;
          end else begin
            r.table_full = 1'b1;
          end
          mirror_open = 1'b0;
        end
      end
      CMD_COVERS: begin
        for (int k = 0; k < mirror_stored; k++) begin
          if (w.ts >= mirror_start[k] && w.ts <= mirror_end[k]) r.found = 1'b1;
        end
        if (mirror_open && w.ts >= mirror_open_ts) r.found = 1'b1;
      end
      default: begin
        if (w.idx < mirror_stored) begin
          r.found = 1'b1;
          r.span_start = mirror_start[w.idx];
          r.span_end = mirror_end[w.idx];
        end else if (mirror_open && w.idx == mirror_stored) begin
          r.found = 1'b1;
          r.span_start = mirror_open_ts;
          r.span_end = TS_ALL_ONES;
        end
      end
    endcase
    r.span_count = CNT_OUT_W'(mirror_stored + (mirror_open ? 1 : 0));
    return r;
  endfunction

  // driver
  int        in_gap_left = 0;
  logic      in_burst = 1'b0;
  logic      in_launch;
  cmd_word_t in_taken;
  cmd_word_t in_next;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      in_launch = 1'b0;
      if (in_valid) begin
        in_taken.cmd = in_cmd;
        in_taken.ts = in_timestamp;
        in_taken.idx = in_span_index;
        span_expect_q.push_back(blackout_predict(in_taken));
      end
      if (in_gap_left != 0) begin
        in_gap_left <= in_gap_left - 1;
      end else if (cmd_pending_q.size() != 0) begin
        in_launch = 1'b1;
        in_next = cmd_pending_q.pop_front();
        in_cmd <= in_next.cmd;
        in_timestamp <= in_next.ts;
        in_span_index <= in_next.idx;
        in_gap_left <= in_burst ? 0 : int'($urandom_range(0, 13));
        if ($urandom_range(0, 39) == 0) in_burst <= ~in_burst;
      end
      in_valid <= in_launch;
    end
  end

  // monitor
  int         out_hold_left = 0;
  int         out_hold_now;
  logic       out_burst = 1'b0;
  span_word_t got_word;
  span_word_t exp_word;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold_left <= 0;
    end else begin
      out_hold_now = out_hold_left;
      if (out_valid && !out_stall) begin
        got_word.found = out_found;
        got_word.span_start = out_span_start;
        got_word.span_end = out_span_end;
        got_word.span_count = out_span_count;
        got_word.table_full = out_table_full;
        if (span_expect_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected word: found %b start %h end %h count %0d full %b",
                     got_word.found, got_word.span_start, got_word.span_end,
                     got_word.span_count, got_word.table_full);
          mismatch_count++;
        end else begin
          exp_word = span_expect_q.pop_front();
          if (got_word !== exp_word) begin
            if (mismatch_count < 10) begin
              $display("mismatch exp: found %b start %h end %h count %0d full %b",
                       exp_word.found, exp_word.span_start, exp_word.span_end,
                       exp_word.span_count, exp_word.table_full);
              $display("         got: found %b start %h end %h count %0d full %b",
                       got_word.found, got_word.span_start, got_word.span_end,
                       got_word.span_count, got_word.table_full);
            end
            mismatch_count++;
          end
        end
        out_hold_now = out_burst ? 0 : int'($urandom_range(0, 13));
        if ($urandom_range(0, 39) == 0) out_burst <= ~out_burst;
      end else if (out_hold_now != 0) begin
        out_hold_now--;
      end
      out_hold_left <= out_hold_now;
      out_stall <= (out_hold_now != 0);
    end
  end

  // stimulus shaping state
  logic            plan_open = 1'b0;
  int unsigned     plan_stored = 0;
  logic [TS_W-1:0] plan_now = 64'd1000;
  logic [TS_W-1:0] plan_marks[$];

  task automatic add_word(logic [CMD_W-1:0] cmd, logic [TS_W-1:0] ts, logic [IDX_W-1:0] idx);
    cmd_word_t w;
    w.cmd = cmd;
    w.ts = ts;
    w.idx = idx;
    cmd_pending_q.push_back(w);
    if (cmd == CMD_OFF && !plan_open) begin
      plan_open = 1'b1;
      plan_marks.push_back(ts);
    end else if (cmd == CMD_ON && plan_open) begin
      plan_open = 1'b0;
      if (plan_stored < SPAN_DEPTH) plan_stored++;
      plan_marks.push_back(ts);
    end
    if (plan_marks.size() > 64) void'(plan_marks.pop_front());
  endtask

  initial begin : stimulus
    int unsigned     pick;
    int unsigned     sel;
    logic [TS_W-1:0] ts;
    logic [TS_W-1:0] mark;

    add_word(CMD_ON, 64'd5, 7'd0);
    add_word(CMD_READ, '0, 7'd0);
    add_word(CMD_COVERS, '0, 7'd0);
    add_word(CMD_OFF, 64'd100, 7'd0);
    add_word(CMD_OFF, 64'd50, 7'd0);
    add_word(CMD_READ, '0, 7'd0);
    add_word(CMD_COVERS, 64'd99, 7'd0);
    add_word(CMD_COVERS, 64'd100, 7'd0);
    add_word(CMD_COVERS, TS_ALL_ONES, 7'd0);
    add_word(CMD_ON, 64'd200, 7'd0);
    add_word(CMD_COVERS, 64'd200, 7'd0);
    add_word(CMD_COVERS, 64'd201, 7'd0);
    add_word(CMD_COVERS, 64'd100, 7'd0);
    // closes earlier than it opened
    add_word(CMD_OFF, TS_ALL_ONES, 7'd0);
    add_word(CMD_ON, '0, 7'd0);
    add_word(CMD_OFF, '0, 7'd0);
    add_word(CMD_ON, '0, 7'd0);
    add_word(CMD_READ, '0, 7'd1);
    add_word(CMD_READ, '0, 7'd2);
    add_word(CMD_READ, '0, 7'd3);
    add_word(CMD_READ, '0, 7'd64);
    add_word(CMD_READ, '0, 7'd127);
    add_word(CMD_COVERS, '0, 7'd0);

    for (int n = 0; n < ITEM_TARGET; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        if ($urandom_range(0, 1) == 0)
          add_word(CMD_OFF, {$urandom(), $urandom()}, IDX_W'($urandom()));
        else
          add_word(CMD_ON, TS_W'($urandom_range(0, 1000)), IDX_W'($urandom()));
      end else if (pick < 20) begin
        plan_now = plan_now + TS_W'($urandom_range(1, 500));
        add_word(plan_open ? CMD_ON : CMD_OFF, plan_now, IDX_W'($urandom()));
      end else if (pick < 60) begin
        sel = $urandom_range(0, 9);
        if (sel < 5 && plan_marks.size() != 0) begin
          mark = plan_marks[$urandom_range(0, plan_marks.size() - 1)];
          ts = mark + TS_W'($urandom_range(0, 2)) - TS_W'(1);
        end else if (sel < 7) begin
          ts = TS_W'($urandom_range(0, 1000)) + (plan_now * TS_W'($urandom_range(0, 1)));
        end else if (sel < 8) begin
          ts = {$urandom(), $urandom()};
        end else if (sel < 9) begin
          ts = ($urandom_range(0, 1) == 0) ? '0 : TS_ALL_ONES;
        end else begin
          ts = plan_now + TS_W'($urandom_range(0, 3));
        end
        add_word(CMD_COVERS, ts, IDX_W'($urandom()));
      end else begin
        if ($urandom_range(0, 99) < 85)
          sel = $urandom_range(0, plan_stored + (plan_open ? 1 : 0) + 1);
        else
          sel = $urandom_range(0, 127);
        add_word(CMD_READ, {$urandom(), $urandom()}, IDX_W'(sel));
      end
    end

    @(posedge rst_n);
    while (cmd_pending_q.size() != 0 || in_valid || span_expect_q.size() != 0)
      @(posedge clk);
    repeat (SPAN_DEPTH + 16) @(posedge clk);
    if (mismatch_count == 0 && span_expect_q.size() == 0) begin
      $display("PASS blackout_span_recorder_core");
    end else begin
      $display("FAIL blackout_span_recorder_core");
    end
    $finish;
  end

endmodule
